### src/rmaa_pkg.sv
// ----------------------------------------------------------------------------
// rmaa_pkg
// Shared constants, the per-item pipeline record and the CORDIC angle table.
// ----------------------------------------------------------------------------
package rmaa_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int LIM       = 2 * ONE;
   localparam int PI_Q13    = 25736;

   // angle accumulator, Q2.30 plus sign and headroom
   localparam int ZW = 34;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   // CORDIC x/y datapath width
   localparam int CW = 20;

   // front sqrt lanes: sine, skew length (shifted left 24), three diagonals
   localparam int SQ_RW    = 58;
   localparam int SQ_N     = SQ_RW / 2;
   localparam int SQ_LANES = 5;

   // axis length sqrt
   localparam int LEN_RW = 32;
   localparam int LEN_N  = LEN_RW / 2;

   // dividers: three by the sine, three by the skew length
   localparam int DIV_DW    = 48;
   localparam int DIV_QW    = 16;
   localparam int DIV_LANES = 6;

   localparam logic [1:0] CASE_GENERAL = 2'd0;
   localparam logic [1:0] CASE_ZERO    = 2'd1;
   localparam logic [1:0] CASE_HALF    = 2'd2;

   typedef struct packed {
      logic signed [17:0]     c;
      logic                   c_pos;
      logic [2:0][16:0]       d;
      logic                   dn_zero;
      logic [15:0]            s;
      logic                   s_zero;
      logic [28:0]            g;
      logic [2:0][14:0]       diag;
      logic [14:0]            ang;
      logic [DIV_LANES-1:0]   ovf;
      logic [2:0][16:0]       vm;
      logic [2:0][16:0]       nm;
   } item_type;

   function automatic logic signed [ZW-1:0] atan_q30(input int i);
      logic signed [ZW-1:0] a;
      case (i)
         0:  a = 34'sd843314857;
         1:  a = 34'sd497837829;
         2:  a = 34'sd263043837;
         3:  a = 34'sd133525159;
         4:  a = 34'sd67021687;
         5:  a = 34'sd33543515;
         6:  a = 34'sd16775851;
         7:  a = 34'sd8388437;
         8:  a = 34'sd4194283;
         9:  a = 34'sd2097149;
         10: a = 34'sd1048576;
         default: a = ZW'(64'h4000_0000 >> i);
      endcase
      return a;
   endfunction

endpackage

### src/rmaa_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmaa_sqrt_cell
// One root bit of a restoring square root, for several lanes, registered.
// ----------------------------------------------------------------------------
module rmaa_sqrt_cell #(
   parameter int LANES = 1,
   parameter int RW    = 2,
   parameter int K     = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           i_valid,
   input  logic [LANES-1:0][RW-1:0]       i_rem,
   input  logic [LANES-1:0][RW/2-1:0]     i_root,
   input  rmaa_pkg::item_type             i_item,
   output logic                           o_valid,
   output logic [LANES-1:0][RW-1:0]       o_rem,
   output logic [LANES-1:0][RW/2-1:0]     o_root,
   output rmaa_pkg::item_type             o_item
);
   import rmaa_pkg::*;

   localparam int N = RW / 2;

   logic                     valid_ff;
   logic [LANES-1:0][RW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][N-1:0]  root_ff, root_in;
   item_type                 item_ff;

   always_comb begin
      logic [RW:0] trial;
      for (int l = 0; l < LANES; l++) begin
         // (Q + 2^K)^2 - Q^2
         trial = ((RW+1)'(i_root[l]) << (K + 1)) + ((RW+1)'(1) << (2 * K));
         if ({1'b0, i_rem[l]} >= trial) begin
            rem_in[l]  = i_rem[l] - trial[RW-1:0];
            root_in[l] = i_root[l] | (N'(1) << K);
         end else begin
            rem_in[l]  = i_rem[l];
            root_in[l] = i_root[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= i_valid;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      item_ff <= i_item;
   end

   assign o_valid = valid_ff;
   assign o_rem   = rem_ff;
   assign o_root  = root_ff;
   assign o_item  = item_ff;

endmodule

### src/rmaa_div_cell.sv
// ----------------------------------------------------------------------------
// rmaa_div_cell
// One quotient bit of a restoring divider, for several lanes, registered.
// ----------------------------------------------------------------------------
module rmaa_div_cell #(
   parameter int LANES = 1,
   parameter int DW    = 2,
   parameter int QW    = 1,
   parameter int K     = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       i_valid,
   input  logic [LANES-1:0][DW-1:0]   i_rem,
   input  logic [LANES-1:0][DW-1:0]   i_den,
   input  logic [LANES-1:0][QW-1:0]   i_quo,
   input  rmaa_pkg::item_type         i_item,
   output logic                       o_valid,
   output logic [LANES-1:0][DW-1:0]   o_rem,
   output logic [LANES-1:0][DW-1:0]   o_den,
   output logic [LANES-1:0][QW-1:0]   o_quo,
   output rmaa_pkg::item_type         o_item
);
   import rmaa_pkg::*;

   logic                     valid_ff;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][DW-1:0] den_ff;
   logic [LANES-1:0][QW-1:0] quo_ff, quo_in;
   item_type                 item_ff;

   always_comb begin
      logic [DW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
         trial = i_den[l] << K;
         if (i_rem[l] >= trial) begin
            rem_in[l] = i_rem[l] - trial;
            quo_in[l] = i_quo[l] | (QW'(1) << K);
         end else begin
            rem_in[l] = i_rem[l];
            quo_in[l] = i_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= i_valid;
      end
      rem_ff  <= rem_in;
      den_ff  <= i_den;
      quo_ff  <= quo_in;
      item_ff <= i_item;
   end

   assign o_valid = valid_ff;
   assign o_rem   = rem_ff;
   assign o_den   = den_ff;
   assign o_quo   = quo_ff;
   assign o_item  = item_ff;

endmodule

### src/rmaa_cordic_cell.sv
// ----------------------------------------------------------------------------
// rmaa_cordic_cell
// One vectoring-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module rmaa_cordic_cell #(
   parameter int K = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               i_valid,
   input  logic signed [rmaa_pkg::CW-1:0]     i_x,
   input  logic signed [rmaa_pkg::CW-1:0]     i_y,
   input  logic signed [rmaa_pkg::ZW-1:0]     i_z,
   input  rmaa_pkg::item_type                 i_item,
   output logic                               o_valid,
   output logic signed [rmaa_pkg::CW-1:0]     o_x,
   output logic signed [rmaa_pkg::CW-1:0]     o_y,
   output logic signed [rmaa_pkg::ZW-1:0]     o_z,
   output rmaa_pkg::item_type                 o_item
);
   import rmaa_pkg::*;

   localparam logic signed [ZW-1:0] ATAN_K = atan_q30(K);

   logic                 valid_ff;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   item_type             item_ff;

   always_comb begin
      if (i_y >= 0) begin
         x_in = i_x + (i_y >>> K);
         y_in = i_y - (i_x >>> K);
         z_in = i_z + ATAN_K;
      end else begin
         x_in = i_x - (i_y >>> K);
         y_in = i_y + (i_x >>> K);
         z_in = i_z - ATAN_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= i_valid;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      item_ff <= i_item;
   end

   assign o_valid = valid_ff;
   assign o_x     = x_ff;
   assign o_y     = y_ff;
   assign o_z     = z_ff;
   assign o_item  = item_ff;

endmodule

### src/rotation_matrix_to_axis_angle.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_axis_angle
// Each item passes through registered stages and the sqrt, CORDIC, divider
// and length sqrt cell rows on its way from start to the result strobe.
// Throughput: one item per cycle; busy never rises and results are not held.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module rotation_matrix_to_axis_angle #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_axis_x,
   output logic signed [15:0] rsp_axis_y,
   output logic signed [15:0] rsp_axis_z,
   output logic [14:0]        rsp_rot_angle,
   output logic [1:0]         rsp_case_code,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import rmaa_pkg::*;

   localparam int LANE_S = 0;
   localparam int LANE_G = 1;
   localparam int LANE_D = 2;

   function automatic logic [15:0] to_out(input logic [16:0] mag, input logic neg);
      logic [16:0] t;
      t = -mag;
      if (neg) return t[15:0];
      else if (mag > 17'd32767) return 16'h7FFF;
      else return mag[15:0];
   endfunction

   // ------------------------------------------------------------------ csr
   logic [7:0] atol_ff;
   logic [9:0] utol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         atol_ff <= 8'd1;
         utol_ff <= 10'd16;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2]) utol_ff <= pwdata[9:0];
         else          atol_ff <= pwdata[7:0];
      end
   end

   assign prdata = paddr[2] ? 32'(utol_ff) : 32'(atol_ff);
   assign pready = 1'b1;
   assign busy   = 1'b0;

   // ------------------------------------------------ stage 1: trace, skew, diagonals
   logic               v1_ff;
   item_type           item1_ff, item1_in;
   logic [2:0][15:0]   rd1_ff, rd1_in;

   always_comb begin
      logic signed [18:0] tr;
      logic signed [16:0] t;
      item1_in = '0;
      tr = 19'(req_m00) + 19'(req_m11) + 19'(req_m22) - 19'(ONE);
      if (tr > 19'(LIM))       item1_in.c = 18'(LIM);
      else if (tr < -19'(LIM)) item1_in.c = -18'(LIM);
      else                     item1_in.c = tr[17:0];
      item1_in.c_pos = (tr > 0);
      item1_in.d[0] = 17'(req_m21) - 17'(req_m12);
      item1_in.d[1] = 17'(req_m02) - 17'(req_m20);
      item1_in.d[2] = 17'(req_m10) - 17'(req_m01);
      t = 17'(req_m00) + 17'(ONE);
      rd1_in[0] = (t < 0) ? 16'd0 : t[15:0];
      t = 17'(req_m11) + 17'(ONE);
      rd1_in[1] = (t < 0) ? 16'd0 : t[15:0];
      t = 17'(req_m22) + 17'(ONE);
      rd1_in[2] = (t < 0) ? 16'd0 : t[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start && !busy;
      item1_ff <= item1_in;
      rd1_ff   <= rd1_in;
   end

   // ------------------------------------------------ stage 2: squares
   logic               v2_ff;
   item_type           item2_ff;
   logic [30:0]        csq_ff, csq_in;
   logic [2:0][31:0]   dsq_ff, dsq_in;
   logic [2:0][28:0]   rdg_ff, rdg_in;

   always_comb begin
      logic signed [35:0] pc;
      logic signed [33:0] pd;
      pc = item1_ff.c * item1_ff.c;
      csq_in = pc[30:0];
      for (int i = 0; i < 3; i++) begin
         pd = $signed(item1_ff.d[i]) * $signed(item1_ff.d[i]);
         dsq_in[i] = pd[31:0];
         rdg_in[i] = {rd1_ff[i], {(FRAC_BITS-1){1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      item2_ff <= item1_ff;
      csq_ff   <= csq_in;
      dsq_ff   <= dsq_in;
      rdg_ff   <= rdg_in;
   end

   // ------------------------------------------------ stage 3: radicands
   logic                              v3_ff;
   item_type                          item3_ff, item3_in;
   logic [SQ_LANES-1:0][SQ_RW-1:0]    rad3_ff, rad3_in;

   always_comb begin
      logic [33:0] dn;
      item3_in = item2_ff;
      dn = 34'(dsq_ff[0]) + 34'(dsq_ff[1]) + 34'(dsq_ff[2]);
      item3_in.dn_zero = (dn == 34'd0);
      rad3_in[LANE_S] = SQ_RW'((31'(1) << (2 * FRAC_BITS + 2)) - csq_ff);
      rad3_in[LANE_G] = {dn, 24'd0};
      for (int i = 0; i < 3; i++) begin
         rad3_in[LANE_D + i] = SQ_RW'(rdg_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      item3_ff <= item3_in;
      rad3_ff  <= rad3_in;
   end

   // ------------------------------------------------ sqrt cell row
   logic                              sq_valid [SQ_N+1];
   logic [SQ_LANES-1:0][SQ_RW-1:0]    sq_rem   [SQ_N+1];
   logic [SQ_LANES-1:0][SQ_N-1:0]     sq_root  [SQ_N+1];
   item_type                          sq_item  [SQ_N+1];

   assign sq_valid[0] = v3_ff;
   assign sq_rem[0]   = rad3_ff;
   assign sq_root[0]  = '0;
   assign sq_item[0]  = item3_ff;

   for (genvar j = 0; j < SQ_N; j++) begin : g_sq
      rmaa_sqrt_cell #(.LANES(SQ_LANES), .RW(SQ_RW), .K(SQ_N - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .i_valid (sq_valid[j]),
         .i_rem   (sq_rem[j]),
         .i_root  (sq_root[j]),
         .i_item  (sq_item[j]),
         .o_valid (sq_valid[j+1]),
         .o_rem   (sq_rem[j+1]),
         .o_root  (sq_root[j+1]),
         .o_item  (sq_item[j+1])
      );
   end

   // ------------------------------------------------ rounding of roots
   logic     vr_ff;
   item_type itemr_ff, itemr_in;

   always_comb begin
      logic [SQ_LANES-1:0][SQ_N:0] q;
      itemr_in = sq_item[SQ_N];
      for (int l = 0; l < SQ_LANES; l++) begin
         q[l] = (SQ_N+1)'(sq_root[SQ_N][l])
              + (SQ_N+1)'(sq_rem[SQ_N][l] > SQ_RW'(sq_root[SQ_N][l]));
      end
      itemr_in.s      = q[LANE_S][15:0];
      itemr_in.s_zero = (q[LANE_S] == '0);
      itemr_in.g      = q[LANE_G][28:0];
      for (int i = 0; i < 3; i++) begin
         itemr_in.diag[i] = q[LANE_D + i][14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vr_ff <= 1'b0;
      else       vr_ff <= sq_valid[SQ_N];
      itemr_ff <= itemr_in;
   end

   // ------------------------------------------------ CORDIC setup
   logic                 vc_ff;
   item_type             itemc_ff;
   logic signed [CW-1:0] xc_ff, xc_in, yc_ff, yc_in;
   logic signed [ZW-1:0] zc_ff, zc_in;

   always_comb begin
      logic signed [CW-1:0] sv;
      sv = CW'($signed({1'b0, itemr_ff.s}));
      if (itemr_ff.c < 0) begin
         // start a quarter turn on so the vector sits in the right half plane
         xc_in = sv;
         yc_in = -CW'(itemr_ff.c);
         zc_in = HALF_PI_Q30;
      end else begin
         xc_in = CW'(itemr_ff.c);
         yc_in = sv;
         zc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vr_ff;
      itemc_ff <= itemr_ff;
      xc_ff    <= xc_in;
      yc_ff    <= yc_in;
      zc_ff    <= zc_in;
   end

   // ------------------------------------------------ CORDIC cell row
   logic                 cr_valid [CORDIC_STAGES+1];
   logic signed [CW-1:0] cr_x     [CORDIC_STAGES+1];
   logic signed [CW-1:0] cr_y     [CORDIC_STAGES+1];
   logic signed [ZW-1:0] cr_z     [CORDIC_STAGES+1];
   item_type             cr_item  [CORDIC_STAGES+1];

   assign cr_valid[0] = vc_ff;
   assign cr_x[0]     = xc_ff;
   assign cr_y[0]     = yc_ff;
   assign cr_z[0]     = zc_ff;
   assign cr_item[0]  = itemc_ff;

   for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_cr
      rmaa_cordic_cell #(.K(j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .i_valid (cr_valid[j]),
         .i_x     (cr_x[j]),
         .i_y     (cr_y[j]),
         .i_z     (cr_z[j]),
         .i_item  (cr_item[j]),
         .o_valid (cr_valid[j+1]),
         .o_x     (cr_x[j+1]),
         .o_y     (cr_y[j+1]),
         .o_z     (cr_z[j+1]),
         .o_item  (cr_item[j+1])
      );
   end

   // ------------------------------------------------ angle, divider setup
   logic                               vp_ff;
   item_type                           itemp_ff, itemp_in;
   logic [DIV_LANES-1:0][DIV_DW-1:0]   nump_ff, nump_in, denp_ff, denp_in;

   always_comb begin
      logic signed [ZW-1:0] za;
      logic signed [16:0]   dv;
      logic [16:0]          mag;
      itemp_in = cr_item[CORDIC_STAGES];
      za = (cr_z[CORDIC_STAGES] + ZW'(65536)) >>> 17;
      if (za < 0)                 itemp_in.ang = '0;
      else if (za > ZW'(PI_Q13))  itemp_in.ang = 15'(PI_Q13);
      else                        itemp_in.ang = za[14:0];
      for (int i = 0; i < 3; i++) begin
         dv  = $signed(itemp_in.d[i]);
         mag = (dv < 0) ? 17'(-dv) : 17'(dv);
         // round half away from zero: add half the divisor to the magnitude
         nump_in[i]     = (DIV_DW'(mag[15:0]) << FRAC_BITS)
                        + DIV_DW'(itemp_in.s >> 1);
         denp_in[i]     = DIV_DW'(itemp_in.s);
         nump_in[3 + i] = (DIV_DW'(mag[15:0]) << (FRAC_BITS + 12))
                        + DIV_DW'(itemp_in.g >> 1);
         denp_in[3 + i] = DIV_DW'(itemp_in.g);
      end
      for (int l = 0; l < DIV_LANES; l++) begin
         itemp_in.ovf[l] = (nump_in[l] >= (denp_in[l] << DIV_QW));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else       vp_ff <= cr_valid[CORDIC_STAGES];
      itemp_ff <= itemp_in;
      nump_ff  <= nump_in;
      denp_ff  <= denp_in;
   end

   // ------------------------------------------------ divider cell row
   logic                              dv_valid [DIV_QW+1];
   logic [DIV_LANES-1:0][DIV_DW-1:0]  dv_rem   [DIV_QW+1];
   logic [DIV_LANES-1:0][DIV_DW-1:0]  dv_den   [DIV_QW+1];
   logic [DIV_LANES-1:0][DIV_QW-1:0]  dv_quo   [DIV_QW+1];
   item_type                          dv_item  [DIV_QW+1];

   assign dv_valid[0] = vp_ff;
   assign dv_rem[0]   = nump_ff;
   assign dv_den[0]   = denp_ff;
   assign dv_quo[0]   = '0;
   assign dv_item[0]  = itemp_ff;

   for (genvar j = 0; j < DIV_QW; j++) begin : g_dv
      rmaa_div_cell #(.LANES(DIV_LANES), .DW(DIV_DW), .QW(DIV_QW),
                      .K(DIV_QW - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .i_valid (dv_valid[j]),
         .i_rem   (dv_rem[j]),
         .i_den   (dv_den[j]),
         .i_quo   (dv_quo[j]),
         .i_item  (dv_item[j]),
         .o_valid (dv_valid[j+1]),
         .o_rem   (dv_rem[j+1]),
         .o_den   (dv_den[j+1]),
         .o_quo   (dv_quo[j+1]),
         .o_item  (dv_item[j+1])
      );
   end

   // ------------------------------------------------ quotient saturation
   logic     vq_ff;
   item_type itemq_ff, itemq_in;

   always_comb begin
      logic [DIV_LANES-1:0][16:0] m;
      itemq_in = dv_item[DIV_QW];
      for (int l = 0; l < DIV_LANES; l++) begin
         if (itemq_in.ovf[l] || dv_quo[DIV_QW][l][DIV_QW-1]) m[l] = 17'(LIM);
         else m[l] = {1'b0, dv_quo[DIV_QW][l]};
      end
      for (int i = 0; i < 3; i++) begin
         itemq_in.vm[i] = m[i];
         itemq_in.nm[i] = m[3 + i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vq_ff <= 1'b0;
      else       vq_ff <= dv_valid[DIV_QW];
      itemq_ff <= itemq_in;
   end

   // ------------------------------------------------ axis squares
   logic             vs_ff;
   item_type         items_ff;
   logic [2:0][30:0] vsq_ff, vsq_in;

   always_comb begin
      logic [33:0] p;
      for (int i = 0; i < 3; i++) begin
         p = itemq_ff.vm[i] * itemq_ff.vm[i];
         vsq_in[i] = p[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vs_ff <= 1'b0;
      else       vs_ff <= vq_ff;
      items_ff <= itemq_ff;
      vsq_ff   <= vsq_in;
   end

   // ------------------------------------------------ length radicand
   logic              vl_ff;
   item_type          iteml_ff;
   logic [LEN_RW-1:0] suml_ff, suml_in;

   assign suml_in = LEN_RW'(vsq_ff[0]) + LEN_RW'(vsq_ff[1]) + LEN_RW'(vsq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) vl_ff <= 1'b0;
      else       vl_ff <= vs_ff;
      iteml_ff <= items_ff;
      suml_ff  <= suml_in;
   end

   // ------------------------------------------------ length sqrt cell row
   logic                   ln_valid [LEN_N+1];
   logic [0:0][LEN_RW-1:0] ln_rem   [LEN_N+1];
   logic [0:0][LEN_N-1:0]  ln_root  [LEN_N+1];
   item_type               ln_item  [LEN_N+1];

   assign ln_valid[0] = vl_ff;
   assign ln_rem[0]   = suml_ff;
   assign ln_root[0]  = '0;
   assign ln_item[0]  = iteml_ff;

   for (genvar j = 0; j < LEN_N; j++) begin : g_ln
      rmaa_sqrt_cell #(.LANES(1), .RW(LEN_RW), .K(LEN_N - 1 - j)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .i_valid (ln_valid[j]),
         .i_rem   (ln_rem[j]),
         .i_root  (ln_root[j]),
         .i_item  (ln_item[j]),
         .o_valid (ln_valid[j+1]),
         .o_rem   (ln_rem[j+1]),
         .o_root  (ln_root[j+1]),
         .o_item  (ln_item[j+1])
      );
   end

   // ------------------------------------------------ case select, output
   logic        rsp_valid_ff;
   logic [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [14:0] ang_ff;
   logic [1:0]  code_ff, code_in;

   always_comb begin
      item_type           it;
      logic [16:0]        len;
      logic signed [17:0] dev;
      logic               zero, half, renorm;
      logic [2:0][15:0]   ax;
      it  = ln_item[LEN_N];
      len = 17'(ln_root[LEN_N][0])
          + 17'(ln_rem[LEN_N][0] > LEN_RW'(ln_root[LEN_N][0]));
      dev = $signed({1'b0, len}) - 18'(ONE);
      if (dev < 0) dev = -dev;
      renorm = (dev > 18'(utol_ff));
      zero = (it.ang < 15'(atol_ff)) || (it.s_zero && it.c_pos);
      half = ((15'(PI_Q13) - it.ang) < 15'(atol_ff)) || it.s_zero;
      for (int i = 0; i < 3; i++) begin
         if (renorm) ax[i] = to_out(it.nm[i], it.d[i][16]);
         else        ax[i] = to_out(it.vm[i], it.d[i][16]);
      end
      if (zero || (!half && it.dn_zero)) begin
         ax_in = 16'(ONE);
         ay_in = '0;
         az_in = '0;
         code_in = CASE_ZERO;
      end else if (half) begin
         ax_in = 16'(it.diag[0]);
         ay_in = 16'(it.diag[1]);
         az_in = 16'(it.diag[2]);
         code_in = CASE_HALF;
      end else begin
         ax_in = ax[0];
         ay_in = ax[1];
         az_in = ax[2];
         code_in = CASE_GENERAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= ln_valid[LEN_N];
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      ang_ff  <= ln_item[LEN_N].ang;
      code_ff <= code_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_axis_x    = ax_ff;
   assign rsp_axis_y    = ay_ff;
   assign rsp_axis_z    = az_ff;
   assign rsp_rot_angle = ang_ff;
   assign rsp_case_code = code_ff;

endmodule
